// ===== design/aisf_pkg.sv =====
// Shared types, constants and helper functions for the AIS sentence MMSI filter.
// No dependencies; imported by aisf_line_tracker and ais_sentence_mmsi_filter.
package aisf_pkg;

  localparam int ID_W       = 30;  // MMSI width
  localparam int SLOT_COUNT = 6;   // six-bit payload characters that carry the MMSI
  localparam int ADDR_W     = 5;   // seven 32-bit registers at 4*i
  localparam int DATA_W     = 32;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_BANG  = 8'h21;  // '!'
  localparam logic [7:0] CHAR_A     = 8'h41;  // 'A'
  localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','

  localparam logic [7:0] ARMOR_BASE = 8'd48;
  localparam logic [7:0] ARMOR_GAP  = 8'd40;
  localparam logic [7:0] ARMOR_SKIP = 8'd8;

  localparam logic [2:0] COMMA_SAT      = 3'd7;
  localparam logic [2:0] PAYLOAD_COMMAS = 3'd5;  // field 5 follows the fifth comma
  localparam logic [3:0] MIN_FIELDS     = 4'd7;
  localparam logic [2:0] POS_SAT        = 3'd7;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MATCH_COUNT = 3'd0;
  localparam logic [2:0] REG_MATCH_ID0   = 3'd1;

  typedef enum logic [2:0] {
    VERDICT_KEPT       = 3'd0,
    VERDICT_SHORT      = 3'd1,
    VERDICT_BAD_PREFIX = 3'd2,
    VERDICT_FEW_FIELDS = 3'd3,
    VERDICT_NO_MATCH   = 3'd4
  } verdict_t;

  // Summary of the line in progress, as the tracker sees it before the newline.
  typedef struct packed {
    logic                  short_line;
    logic                  bad_prefix;
    logic                  few_fields;
    logic [ID_W-1:0]       shadow_id;
    logic [SLOT_COUNT-1:0] shadow_written;
  } line_status_t;

  // Six-bit de-armoring; codes below '0' and bytes with the top bit set give 0.
  function automatic logic [5:0] dearmor(input logic [7:0] b);
    logic [7:0] v;
    begin
      v = 8'd0;
      if (!b[7] && (b >= ARMOR_BASE)) begin
        v = b - ARMOR_BASE;
        if (v >= ARMOR_GAP) v = v - ARMOR_SKIP;
      end
      return v[5:0];
    end
  endfunction

  // MMSI bits covered by each slot: 4 bits, then four full characters, then 2 bits.
  function automatic logic [ID_W-1:0] slot_mask(input logic [2:0] s);
    logic [ID_W-1:0] m;
    begin
      case (s)
        3'd0:    m = {4'hF, 26'd0};
        3'd1:    m = {4'd0, 6'h3F, 20'd0};
        3'd2:    m = {10'd0, 6'h3F, 14'd0};
        3'd3:    m = {16'd0, 6'h3F, 8'd0};
        3'd4:    m = {22'd0, 6'h3F, 2'd0};
        default: m = {28'd0, 2'h3};
      endcase
      return m;
    end
  endfunction

  function automatic logic [ID_W-1:0] slot_bits(input logic [2:0] s, input logic [5:0] v);
    logic [ID_W-1:0] r;
    begin
      case (s)
        3'd0:    r = {v[3:0], 26'd0};
        3'd1:    r = {4'd0, v, 20'd0};
        3'd2:    r = {10'd0, v, 14'd0};
        3'd3:    r = {16'd0, v, 8'd0};
        3'd4:    r = {22'd0, v, 2'd0};
        default: r = {28'd0, v[5:4]};
      endcase
      return r;
    end
  endfunction

endpackage

// ===== design/aisf_line_tracker.sv =====
// Per-line state: length, prefix check, comma count and the MMSI shadow slots.
// Depends on aisf_pkg.
module aisf_line_tracker #(
  parameter int MIN_LINE_LENGTH = 20
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [7:0]            in_char,
  output aisf_pkg::line_status_t status
);
  import aisf_pkg::*;

  localparam logic [4:0] MIN_LEN = 5'(MIN_LINE_LENGTH);

  logic [4:0]            line_length_r, line_length_nxt;
  logic                  prefix_good_r, prefix_good_nxt;
  logic [2:0]            comma_total_r, comma_total_nxt;
  logic                  ended_on_comma_r, ended_on_comma_nxt;
  logic [2:0]            payload_position_r, payload_position_nxt;
  logic [ID_W-1:0]       shadow_id_r, shadow_id_nxt;
  logic [SLOT_COUNT-1:0] shadow_written_r, shadow_written_nxt;

  logic [2:0] slot;
  logic [3:0] field_total;

  always_comb begin
    line_length_nxt      = line_length_r;
    prefix_good_nxt      = prefix_good_r;
    comma_total_nxt      = comma_total_r;
    ended_on_comma_nxt   = ended_on_comma_r;
    payload_position_nxt = payload_position_r;
    shadow_id_nxt        = shadow_id_r;
    shadow_written_nxt   = shadow_written_r;
    slot                 = payload_position_r - 3'd1;
    if (step) begin
      if (in_char == CHAR_NL) begin
        line_length_nxt      = 5'd0;
        prefix_good_nxt      = 1'b1;
        comma_total_nxt      = 3'd0;
        ended_on_comma_nxt   = 1'b0;
        payload_position_nxt = 3'd0;
        shadow_written_nxt   = '0;
      end else begin
        if (line_length_r == 5'd0 && in_char != CHAR_BANG) prefix_good_nxt = 1'b0;
        if (line_length_r == 5'd1 && in_char != CHAR_A)    prefix_good_nxt = 1'b0;
        if (line_length_r < MIN_LEN) line_length_nxt = line_length_r + 5'd1;
        if (in_char == CHAR_COMMA) begin
          if (comma_total_r < COMMA_SAT) comma_total_nxt = comma_total_r + 3'd1;
          ended_on_comma_nxt = 1'b1;
        end else begin
          ended_on_comma_nxt = 1'b0;
          if (comma_total_r == PAYLOAD_COMMAS) begin
            if (payload_position_r >= 3'd1 && payload_position_r <= 3'd6) begin
              shadow_id_nxt = (shadow_id_r & ~slot_mask(slot))
                            | slot_bits(slot, dearmor(in_char));
              shadow_written_nxt[slot] = 1'b1;
            end
            if (payload_position_r < POS_SAT) payload_position_nxt = payload_position_r + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r      <= 5'd0;
      prefix_good_r      <= 1'b1;
      comma_total_r      <= 3'd0;
      ended_on_comma_r   <= 1'b0;
      payload_position_r <= 3'd0;
      shadow_written_r   <= '0;
    end else begin
      line_length_r      <= line_length_nxt;
      prefix_good_r      <= prefix_good_nxt;
      comma_total_r      <= comma_total_nxt;
      ended_on_comma_r   <= ended_on_comma_nxt;
      payload_position_r <= payload_position_nxt;
      shadow_written_r   <= shadow_written_nxt;
    end
  end

  // Unwritten shadow bits are masked off by shadow_written, so no reset here.
  always_ff @(posedge clk) begin
    shadow_id_r <= shadow_id_nxt;
  end

  assign field_total = ended_on_comma_r ? {1'b0, comma_total_r}
                                        : {1'b0, comma_total_r} + 4'd1;

  always_comb begin
    status.short_line     = (line_length_r < MIN_LEN);
    status.bad_prefix     = !prefix_good_r;
    status.few_fields     = (field_total < MIN_FIELDS);
    status.shadow_id      = shadow_id_r;
    status.shadow_written = shadow_written_r;
  end

endmodule

// ===== design/ais_sentence_mmsi_filter.sv =====
// AIS sentence filter by MMSI: top level with input register, result register
// and APB-style configuration registers. Depends on aisf_pkg, aisf_line_tracker.
// Throughput: one byte per cycle while no newline waits on an unread result. A
// newline passes the input register, then loads the result register.
// A newline waits in the input register only while a result is still unread.
// Reset (rst_n, synchronous): line state cleared, committed MMSI and registers to 0.
module ais_sentence_mmsi_filter #(
  parameter int MATCH_SLOTS     = 6,
  parameter int MIN_LINE_LENGTH = 20
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // byte stream in
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_byte,
  // one result per line
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_keep_line,
  output logic [aisf_pkg::ID_W-1:0]   out_vessel_id,
  output logic [2:0]                  out_verdict,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [aisf_pkg::ADDR_W-1:0] paddr,
  input  logic [aisf_pkg::DATA_W-1:0] pwdata,
  output logic [aisf_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import aisf_pkg::*;

  // ---------------------------------------------------------------------------
  // Configuration registers: match_count at 0, match_id_k at 4*(k+1).
  // Only MATCH_SLOTS id entries exist; writes to the rest are dropped.
  // ---------------------------------------------------------------------------
  logic [2:0]      match_count_r;
  logic [ID_W-1:0] match_id_r [MATCH_SLOTS];
  logic [2:0]      reg_index;
  logic            cfg_write;

  assign pready    = 1'b1;
  assign reg_index = paddr[ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_count_r <= 3'd0;
    end else if (cfg_write && reg_index == REG_MATCH_COUNT) begin
      match_count_r <= pwdata[2:0];
    end
  end

  for (genvar k = 0; k < MATCH_SLOTS; k++) begin : g_id
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        match_id_r[k] <= '0;
      end else if (cfg_write && reg_index == REG_MATCH_ID0 + 3'(k)) begin
        match_id_r[k] <= pwdata[ID_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_index == REG_MATCH_COUNT) prdata = {29'd0, match_count_r};
    for (int k = 0; k < MATCH_SLOTS; k++) begin
      if (reg_index == REG_MATCH_ID0 + 3'(k)) prdata = {2'd0, match_id_r[k]};
    end
  end

  // ---------------------------------------------------------------------------
  // Input register. Ordinary bytes always move on; a newline needs the result
  // register free. in_ready stays high while the register drains.
  // ---------------------------------------------------------------------------
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       advance;
  logic       line_end;
  logic       out_free;
  logic       out_valid_r;

  assign line_end = in_valid_r && (in_byte_r == CHAR_NL);
  assign out_free = !out_valid_r || out_ready;
  assign advance  = in_valid_r && (!line_end || out_free);
  assign in_ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) in_byte_r <= in_byte;
  end

  // ---------------------------------------------------------------------------
  // Line tracking
  // ---------------------------------------------------------------------------
  line_status_t status;

  aisf_line_tracker #(
    .MIN_LINE_LENGTH (MIN_LINE_LENGTH)
  ) u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (advance),
    .in_char (in_byte_r),
    .status  (status)
  );

  // ---------------------------------------------------------------------------
  // End of line: verdict, commit of written slots, parallel id compare.
  // ---------------------------------------------------------------------------
  logic [ID_W-1:0] committed_id_r;
  logic [ID_W-1:0] write_mask;
  logic [ID_W-1:0] merged_id;
  logic            commit;
  logic            hit;
  logic            line_done;
  verdict_t        verdict;

  assign line_done = advance && line_end;
  assign commit    = !status.short_line && !status.bad_prefix && !status.few_fields;

  always_comb begin
    write_mask = '0;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (status.shadow_written[s]) write_mask = write_mask | slot_mask(3'(s));
    end
  end

  assign merged_id = (committed_id_r & ~write_mask) | (status.shadow_id & write_mask);

  // match_count above MATCH_SLOTS simply enables every entry
  always_comb begin
    hit = 1'b0;
    for (int k = 0; k < MATCH_SLOTS; k++) begin
      if (3'(k) < match_count_r && match_id_r[k] == merged_id) hit = 1'b1;
    end
  end

  always_comb begin
    if (status.short_line)      verdict = VERDICT_SHORT;
    else if (status.bad_prefix) verdict = VERDICT_BAD_PREFIX;
    else if (status.few_fields) verdict = VERDICT_FEW_FIELDS;
    else if (hit)               verdict = VERDICT_KEPT;
    else                        verdict = VERDICT_NO_MATCH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      committed_id_r <= '0;
    end else if (line_done && commit) begin
      committed_id_r <= merged_id;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic            out_keep_r;
  logic [ID_W-1:0] out_id_r;
  verdict_t        out_verdict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (line_done) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (line_done) begin
      out_keep_r    <= (verdict == VERDICT_KEPT);
      out_id_r      <= commit ? merged_id : committed_id_r;
      out_verdict_r <= verdict;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_keep_line = out_keep_r;
  assign out_vessel_id = out_id_r;
  assign out_verdict   = out_verdict_r;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  a_keep_vs_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_keep_r == (out_verdict_r == VERDICT_KEPT)))
    else $error("keep flag disagrees with verdict");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (line_end && out_valid_r && !out_ready))
    else $error("input stalled without a pending result");

  a_commit_only_at_eol: assert property (@(posedge clk) disable iff (!rst_n)
    !(line_done && commit) |=> $stable(committed_id_r))
    else $error("committed MMSI changed outside a passing line end");

  a_reject_shows_old_id: assert property (@(posedge clk) disable iff (!rst_n)
    (line_done && !commit) |=> (out_id_r == $past(committed_id_r)))
    else $error("rejected line did not report the prior MMSI");

  a_result_matches_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (line_done && commit) |=> (out_id_r == committed_id_r))
    else $error("reported MMSI differs from committed value");

endmodule
